// ----- hw/rtl/sblfu_pkg.sv -----
// shared types and constants for the size-budgeted lfu cache directory
// no dependencies
package sblfu_pkg;
    localparam int Entries = 16;
    localparam int IdxW    = $clog2(Entries);
    localparam int CntW    = $clog2(Entries + 1);
    localparam int KeyW    = 32;
    localparam int StampW  = 32;
    localparam int SizeW   = 24;
    localparam int UsesW   = 32;
    localparam int TotW    = 28;
    localparam int StatW   = 3;
    localparam int EntW    = KeyW + SizeW + StampW + UsesW + 1;

    localparam logic [StatW-1:0] StMiss   = 3'd0;
    localparam logic [StatW-1:0] StHit    = 3'd1;
    localparam logic [StatW-1:0] StStale  = 3'd2;
    localparam logic [StatW-1:0] StStored = 3'd3;
    localparam logic [StatW-1:0] StReject = 3'd4;

    localparam logic [TotW-1:0] BudgetReset = 28'd1048576;

    typedef struct packed {
        logic [KeyW-1:0]   key;
        logic [SizeW-1:0]  size;
        logic [StampW-1:0] stamp;
        logic [UsesW-1:0]  uses;
        logic              stale;
    } t_entry;

    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] waddr;
        t_entry          wdata;
        logic [IdxW-1:0] raddr;
    } t_mem_req;
endpackage

// ----- hw/rtl/sblfu_mem.sv -----
// entry memory of the directory, one write and one registered read port
// depends on sblfu_pkg
module sblfu_mem (
    input  logic                i_clk,
    input  sblfu_pkg::t_mem_req i_req,
    output sblfu_pkg::t_entry   o_rdata
);
    import sblfu_pkg::*;

    t_entry r_mem [Entries];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/size_budget_lfu_cache_directory.sv -----
// size-budgeted lfu cache directory: sequencer around the entry memory
// depends on sblfu_pkg and sblfu_mem
//
// channel   dir  content
// s_axis    in   tdata {obj_size, stamp, key} tuser action
// m_axis    out  tdata {bytes_used, slot, status}
// cfg       in   i_cfg_we / i_cfg_wdata: byte budget
//
// one item at a time; every pass over the directory reads one entry a cycle
// from the memory through its registered read port
// get and set on a known key: lookup and update; set on a new key:
// lookup, purge, up to three eviction scans, purge, append
// reset clears count and total and reloads the default budget; no clearing pass
// the output register holds a result until taken; no new item meanwhile
module size_budget_lfu_cache_directory (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [27:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,   // key, stamp, obj_size
    input  logic         s_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata    // status, slot, bytes_used, zero pad
);
    import sblfu_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FIND  = 10'b0000000010,
        S_HIT   = 10'b0000000100,
        S_PURGE = 10'b0000001000,
        S_CHK   = 10'b0000010000,
        S_EV1   = 10'b0000100000,
        S_EV2   = 10'b0001000000,
        S_EV3   = 10'b0010000000,
        S_APP   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state             r_state;
    logic [TotW-1:0]    r_budget;
    logic [CntW-1:0]    r_count;
    logic [TotW-1:0]    r_total;
    logic               r_act;
    logic [KeyW-1:0]    r_key;
    logic [StampW-1:0]  r_stamp;
    logic [SizeW-1:0]   r_size;
    logic [CntW-1:0]    r_rd;      // read pointer issued
    logic [CntW-1:0]    r_ix;      // index of the entry in rdata
    logic               r_dv;      // rdata valid
    logic [CntW-1:0]    r_wr;      // compaction write pointer
    logic [IdxW-1:0]    r_hidx;
    logic               r_have;
    logic [UsesW-1:0]   r_best;
    logic [IdxW-1:0]    r_vict;
    logic [SizeW:0]     r_freed;
    logic               r_done;
    logic               r_pass;    // purge: 0 stale only, 1 stale or victim marks
    logic [Entries-1:0] r_mark;
    logic [StatW-1:0]   r_status;
    logic [IdxW-1:0]    r_slot;
    logic               r_ovalid;

    t_mem_req mreq;
    t_entry   rdata;

    sblfu_mem u_mem (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));

    logic            last_rd;
    logic [IdxW-1:0] ixi;
    logic [TotW:0]   upd_sum;
    logic [TotW:0]   app_sum;
    logic            drop;

    assign ixi      = r_ix[IdxW-1:0];
    assign last_rd  = (r_rd == r_count);
    assign upd_sum  = {1'b0, r_total} - {{(TotW-SizeW+1){1'b0}}, rdata.size}
                      + {{(TotW-SizeW+1){1'b0}}, r_size};
    assign app_sum  = {1'b0, r_total} + {{(TotW-SizeW+1){1'b0}}, r_size};
    assign drop     = rdata.stale || (r_pass && r_mark[ixi]);

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_total, r_slot, r_status};

    always_comb begin
        mreq       = '0;
        mreq.raddr = r_rd[IdxW-1:0];
        mreq.wdata = rdata;
        case (r_state)
            S_FIND: begin
                // re-read the matching entry for the update
                if (r_dv && rdata.key == r_key) begin
                    mreq.raddr = ixi;
                end
            end
            S_HIT: begin
                mreq.waddr = r_hidx;
                if (r_act == 1'b0) begin
                    if (rdata.size != r_size || rdata.stamp != r_stamp) begin
                        mreq.we = 1'b1;
                        mreq.wdata.stale = 1'b1;
                    end else begin
                        mreq.we = 1'b1;
                        if (rdata.uses != '1) begin
                            mreq.wdata.uses = rdata.uses + 1'b1;
                        end
                    end
                end else if (upd_sum <= {1'b0, r_budget}) begin
                    mreq.we = 1'b1;
                    mreq.wdata.size  = r_size;
                    mreq.wdata.stamp = r_stamp;
                    mreq.wdata.stale = 1'b0;
                end
            end
            S_PURGE: begin
                mreq.waddr = r_wr[IdxW-1:0];
                mreq.wdata.stale = 1'b0;
                mreq.we = r_dv && !drop;
            end
            S_APP: begin
                mreq.waddr = r_count[IdxW-1:0];
                mreq.wdata = '{key: r_key, size: r_size, stamp: r_stamp,
                               uses: '0, stale: 1'b0};
                mreq.we = (app_sum <= {1'b0, r_budget}) &&
                          (r_count < CntW'(Entries));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_budget <= BudgetReset;
            r_count  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_dv <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_act   <= s_axis_tuser;
                        r_key   <= s_axis_tdata[31:0];
                        r_stamp <= s_axis_tdata[63:32];
                        r_size  <= s_axis_tdata[87:64];
                        r_rd    <= '0;
                        r_status <= StMiss;
                        r_slot  <= '0;
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    // scan keys, first match wins
                    if (r_dv && rdata.key == r_key) begin
                        r_hidx  <= ixi;
                        r_rd    <= CntW'(ixi);
                        r_state <= S_HIT;
                    end else if (last_rd && !r_dv) begin
                        if (r_act == 1'b0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_rd <= '0; r_wr <= '0; r_pass <= 1'b0;
                            r_state <= S_PURGE;
                        end
                    end else if (!last_rd) begin
                        r_rd <= r_rd + 1'b1;
                        r_ix <= r_rd;
                        r_dv <= 1'b1;
                    end
                end
                S_HIT: begin
                    // rdata holds the matching entry, read again on the match cycle
                    if (r_act == 1'b0) begin
                        if (rdata.size != r_size || rdata.stamp != r_stamp) begin
                            r_status <= StStale;
                        end else begin
                            r_status <= StHit;
                            r_slot   <= r_hidx;
                        end
                    end else if (upd_sum <= {1'b0, r_budget}) begin
                        r_total  <= upd_sum[TotW-1:0];
                        r_status <= StStored;
                        r_slot   <= r_hidx;
                    end else begin
                        r_status <= StReject;
                    end
                    r_state <= S_OUT;
                end
                S_PURGE: begin
                    if (r_dv) begin
                        if (drop) begin
                            r_total <= r_total - TotW'(rdata.size);
                        end else begin
                            r_wr <= r_wr + 1'b1;
                        end
                    end
                    if (!last_rd) begin
                        r_rd <= r_rd + 1'b1;
                        r_ix <= r_rd;
                        r_dv <= 1'b1;
                    end else if (!r_dv) begin
                        r_count <= r_wr;
                        r_state <= (r_pass) ? S_APP : S_CHK;
                    end
                end
                S_CHK: begin
                    r_mark <= '0;
                    r_have <= 1'b0;
                    r_rd   <= '0;
                    r_state <= (app_sum > {1'b0, r_budget}) ? S_EV1 : S_APP;
                end
                S_EV1: begin
                    // least uses among entries at least obj_size, first wins
                    if (r_dv && rdata.size >= r_size &&
                        (!r_have || rdata.uses < r_best)) begin
                        r_have <= 1'b1;
                        r_best <= rdata.uses;
                        r_vict <= ixi;
                    end
                    if (!last_rd) begin
                        r_rd <= r_rd + 1'b1;
                        r_ix <= r_rd;
                        r_dv <= 1'b1;
                    end else if (!r_dv) begin
                        r_rd <= '0;
                        if (r_have) begin
                            r_mark[r_vict] <= 1'b1;
                            r_wr <= '0; r_pass <= 1'b1;
                            r_state <= S_PURGE;
                        end else if (r_count == '0) begin
                            r_state <= S_APP;
                        end else begin
                            r_state <= S_EV2;
                        end
                    end
                end
                S_EV2: begin
                    // global minimum of use counts
                    if (r_dv && (r_ix == '0 || rdata.uses < r_best)) begin
                        r_best <= rdata.uses;
                    end
                    if (!last_rd) begin
                        r_rd <= r_rd + 1'b1;
                        r_ix <= r_rd;
                        r_dv <= 1'b1;
                    end else if (!r_dv) begin
                        r_rd <= '0;
                        r_freed <= '0;
                        r_done <= 1'b0;
                        r_state <= S_EV3;
                    end
                end
                S_EV3: begin
                    if (r_dv && !r_done && rdata.uses <= r_best) begin
                        if (r_freed >= {1'b0, r_size}) begin
                            r_done <= 1'b1;
                        end else begin
                            r_mark[ixi] <= 1'b1;
                            r_freed <= r_freed + {1'b0, rdata.size};
                        end
                    end
                    if (!last_rd) begin
                        r_rd <= r_rd + 1'b1;
                        r_ix <= r_rd;
                        r_dv <= 1'b1;
                    end else if (!r_dv) begin
                        r_rd <= '0; r_wr <= '0; r_pass <= 1'b1;
                        r_state <= S_PURGE;
                    end
                end
                S_APP: begin
                    if (mreq.we) begin
                        r_total  <= app_sum[TotW-1:0];
                        r_count  <= r_count + 1'b1;
                        r_status <= StStored;
                        r_slot   <= r_count[IdxW-1:0];
                    end else begin
                        r_status <= StReject;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Entries)) else $error("entry count out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_total))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("accept while busy");
    a_reject_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_status == StReject |-> r_slot == '0)
        else $error("reject carries a slot");
endmodule

// ----- bench/testbench.sv -----
// testbench for the size-budgeted lfu cache directory: directed and random gets/sets
// with a behavioral model of the directory; depends on sblfu_pkg and the rtl top
`timescale 1ns / 100ps

module testbench;
    import sblfu_pkg::*;

    localparam logic ActGet = 1'b0;
    localparam logic ActSet = 1'b1;

    typedef struct packed {
        logic [TotW-1:0]  bytes_used;
        logic [IdxW-1:0]  slot;
        logic [StatW-1:0] status;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [27:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;   // key, stamp, obj_size
    logic        s_axis_tuser = 1'b0; // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // status, slot, bytes_used, zero pad

    size_budget_lfu_cache_directory u_top (.*);

    initial forever #4 i_clk = ~i_clk;

    // directory model
    logic [KeyW-1:0]   dir_key   [Entries];
    logic [SizeW-1:0]  dir_size  [Entries];
    logic [StampW-1:0] dir_stamp [Entries];
    logic [UsesW-1:0]  dir_uses  [Entries];
    logic              dir_stale [Entries];
    int                dir_count;
    logic [TotW-1:0]   dir_total;
    logic [TotW-1:0]   budget;

    t_result pending_results[$];
    int      errors;
    int      n_sent;
    int      n_checked;
    int      status_seen[5];
    bit      rx_stall_off;

    function automatic void purge_stale();
        int w;
        w = 0;
        for (int r = 0; r < dir_count; r++) begin
            if (dir_stale[r]) begin
                dir_total = dir_total - TotW'(dir_size[r]);
            end else begin
                dir_key[w] = dir_key[r];
                dir_size[w] = dir_size[r];
                dir_stamp[w] = dir_stamp[r];
                dir_uses[w] = dir_uses[r];
                dir_stale[w] = 1'b0;
                w++;
            end
        end
        dir_count = w;
    endfunction

    function automatic void evict_for(logic [SizeW-1:0] need);
        logic [UsesW-1:0] least;
        bit               have;
        int               marked;
        longint unsigned  freed;
        least = '0;
        have = 0;
        marked = 0;
        freed = 0;
        for (int i = 0; i < dir_count; i++)
            if (dir_size[i] >= need && (!have || dir_uses[i] < least)) begin
                least = dir_uses[i];
                have = 1;
            end
        if (have)
            for (int i = 0; i < dir_count; i++)
                if (dir_size[i] >= need && dir_uses[i] <= least) begin
                    dir_stale[i] = 1'b1;
                    marked++;
                    break;
                end
        if (marked == 0 && dir_count > 0) begin
            least = dir_uses[0];
            for (int i = 1; i < dir_count; i++)
                if (dir_uses[i] < least) least = dir_uses[i];
            for (int i = 0; i < dir_count; i++)
                if (dir_uses[i] <= least) begin
                    if (freed >= need) break;
                    dir_stale[i] = 1'b1;
                    freed += dir_size[i];
                    marked++;
                end
        end
        if (marked > 0) purge_stale();
    endfunction

    function automatic t_result directory_access(logic act, logic [KeyW-1:0] key,
                                                 logic [StampW-1:0] stamp,
                                                 logic [SizeW-1:0] size);
        t_result         res;
        int              idx;
        longint unsigned t;
        res = '{'0, '0, StMiss};
        idx = -1;
        for (int i = 0; i < dir_count; i++)
            if (dir_key[i] == key) begin
                idx = i;
                break;
            end
        if (act == ActGet) begin
            if (idx >= 0) begin
                if (dir_size[idx] != size || dir_stamp[idx] != stamp) begin
                    dir_stale[idx] = 1'b1;
                    res.status = StStale;
                end else begin
                    if (dir_uses[idx] != '1) dir_uses[idx]++;
                    res.status = StHit;
                    res.slot = IdxW'(idx);
                end
            end
        end else if (idx >= 0) begin
            t = longint'(dir_total) - dir_size[idx] + size;
            if (t <= budget) begin
                dir_size[idx] = size;
                dir_stamp[idx] = stamp;
                dir_stale[idx] = 1'b0;
                dir_total = TotW'(t);
                res.status = StStored;
                res.slot = IdxW'(idx);
            end else begin
                res.status = StReject;
            end
        end else begin
            purge_stale();
            if (longint'(dir_total) + size > budget) evict_for(size);
            if (longint'(dir_total) + size <= budget && dir_count < Entries) begin
                dir_key[dir_count] = key;
                dir_size[dir_count] = size;
                dir_stamp[dir_count] = stamp;
                dir_uses[dir_count] = '0;
                dir_stale[dir_count] = 1'b0;
                dir_total = dir_total + TotW'(size);
                res.status = StStored;
                res.slot = IdxW'(dir_count);
                dir_count++;
            end else begin
                res.status = StReject;
            end
        end
        res.bytes_used = dir_total;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want,
                 n_checked);
        errors++;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_request(logic act, logic [KeyW-1:0] key, logic [StampW-1:0] stamp,
                                logic [SizeW-1:0] size);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {size, stamp, key};
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(directory_access(act, key, stamp, size));
        n_sent++;
        if ($urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            idle_gap();
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [TotW-1:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        budget = value;
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[StatW+IdxW+TotW-1:0];
            if (pending_results.size() == 0) begin
                $display("unexpected result transfer");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
                if (got.bytes_used != want.bytes_used)
                    report_mismatch("bytes_used", got.bytes_used, want.bytes_used);
                if (want.status <= StReject) status_seen[want.status]++;
                n_checked++;
            end
        end
        if (rx_stall_off) m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 30) == 0) m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) m_axis_tready <= 1'b1;
    end

    task automatic test_directed();
        send_request(ActGet, 32'h0, 32'h0, 24'h0);
        send_request(ActSet, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_request(ActSet, 32'h0, 32'h0, 24'h0);
        send_request(ActSet, 32'h1, 32'h10, 24'h100);
        send_request(ActGet, 32'h1, 32'h10, 24'h100);
        send_request(ActGet, 32'h1, 32'h10, 24'h100);
        send_request(ActGet, 32'h0, 32'h0, 24'h0);
        send_request(ActGet, 32'h1, 32'h11, 24'h100);
        send_request(ActSet, 32'h1, 32'h20, 24'h200);
        send_request(ActSet, 32'h2, 32'h5, 24'h10);
        send_request(ActGet, 32'h2, 32'h5, 24'h11);
        send_request(ActSet, 32'h3, 32'h5, 24'hF_0000);
        send_request(ActSet, 32'h1, 32'h5, 24'hF_FFFF);
        send_request(ActSet, 32'h4, 32'h5, 24'h9_0000);
        send_request(ActGet, 32'h55, 32'h0, 24'h0);
    endtask

    task automatic test_fill_and_evict();
        for (int i = 0; i < 20; i++)
            send_request(ActSet, 32'h100 + i, i,
                         SizeW'(24'h8000 + $urandom_range(0, 255)));
    endtask

    task automatic test_random(int n_items);
        logic [KeyW-1:0]   k;
        logic [StampW-1:0] st;
        logic [SizeW-1:0]  sz;
        int                idx;
        for (int i = 0; i < n_items; i++) begin
            idx = (dir_count > 0) ? $urandom_range(0, dir_count - 1) : 0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    if (dir_count > 0) begin
                        k = dir_key[idx];
                        st = dir_stamp[idx];
                        sz = dir_size[idx];
                        if ($urandom_range(0, 5) == 0) st ^= 32'(1) << $urandom_range(0, 31);
                        if ($urandom_range(0, 5) == 0) sz ^= 24'(1) << $urandom_range(0, 23);
                    end else begin
                        k = $urandom_range(0, 40);
                        st = $urandom();
                        sz = SizeW'($urandom_range(0, 4096));
                    end
                    send_request(ActGet, k, st, sz);
                end
                4: begin
                    k = (dir_count > 0) ? dir_key[idx] : $urandom();
                    send_request(ActSet, k, $urandom(),
                                 SizeW'($urandom_range(0, budget >> 3)));
                end
                5, 6, 7, 8: begin
                    k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 60) : $urandom();
                    sz = ($urandom_range(0, 12) == 0) ? SizeW'($urandom()) :
                         SizeW'($urandom_range(0, (budget >> 2) & 24'hFF_FFFF));
                    send_request(ActSet, k, $urandom(), sz);
                end
                default: send_request(ActGet, $urandom(), $urandom(), SizeW'($urandom()));
            endcase
        end
    endtask

    initial begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        rx_stall_off = 0;
        budget = BudgetReset;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_evict();
        write_budget(28'd0);
        test_random(40);
        write_budget(28'hFFF_FFFF);
        test_random(150);
        rx_stall_off = 1;
        write_budget(28'd60000);
        test_fill_and_evict();
        test_random(250);
        rx_stall_off = 0;
        write_budget(28'd1000);
        test_random(100);
        write_budget(28'd3000000);
        test_random(200);
        write_budget(28'h800_0000);
        test_random(60);
        drain();
        $display("sent %0d requests, checked %0d results", n_sent, n_checked);
        $display("miss %0d hit %0d stale %0d stored %0d rejected %0d", status_seen[0],
                 status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
        if (errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench failed");
        $finish;
    end
endmodule
